/* rtl/core/uds_session_security_server_assert.svh */
// Assertion macros shared by the session security server modules.
`ifndef UDS_SESSION_SECURITY_SERVER_ASSERT_SVH
`define UDS_SESSION_SECURITY_SERVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UDS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UDS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define UDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/uds_pkg.sv */
// Types, codes and constants of the session security server.
`default_nettype none
package uds_pkg;
    typedef struct packed {
        logic       kind;
        logic [7:0] req_len;
        logic [7:0] service_id;
        logic [7:0] sub_func;
        logic [7:0] pay0;
        logic [7:0] pay1;
        logic [7:0] pay2;
        logic [7:0] pay3;
        logic       clear_ok;
    } in_word_t;

    typedef struct packed {
        logic [2:0] resp_len;
        logic [7:0] resp0;
        logic [7:0] resp1;
        logic [7:0] resp2;
        logic [7:0] resp3;
        logic [7:0] resp4;
        logic [7:0] resp5;
        logic [1:0] action;
    } out_word_t;

    typedef enum logic [1:0] {
        CFG_S3_TIMEOUT = 2'd0,
        CFG_TICK_STEP  = 2'd1,
        CFG_MAX_ATT    = 2'd2,
        CFG_KEY_SECRET = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_FWD   = 2'd3
    } action_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture input word
        logic decide;   // evaluate the word, update state, form response
        logic lcg_step; // advance the generator by one step
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_seed; // decided word draws a fresh seed
    } dp_stat_t;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_ADD     = 32'd12345;
    localparam logic [31:0] LCG_INIT    = 32'h12345678;
    localparam int          SEED_BYTES  = 4;
    localparam logic [7:0]  MAX_REQ_LEN = 8'd255;

    localparam logic [7:0] SID_SESSION = 8'h10;
    localparam logic [7:0] SID_RESET   = 8'h11;
    localparam logic [7:0] SID_CLEAR   = 8'h14;
    localparam logic [7:0] SID_RDID    = 8'h22;
    localparam logic [7:0] SID_SEC     = 8'h27;
    localparam logic [7:0] SID_TESTER  = 8'h3E;
    localparam logic [7:0] NEG_RESP    = 8'h7F;

    localparam logic [7:0] NRC_SNS  = 8'h11;
    localparam logic [7:0] NRC_SFNS = 8'h12;
    localparam logic [7:0] NRC_LEN  = 8'h13;
    localparam logic [7:0] NRC_ROOR = 8'h31;
    localparam logic [7:0] NRC_KEY  = 8'h35;
    localparam logic [7:0] NRC_ATT  = 8'h36;
endpackage
`default_nettype wire

/* rtl/core/uds_ctrl.sv */
// Controller sequencing load, decision, seed generation and output.
`default_nettype none
`include "uds_session_security_server_assert.svh"
module uds_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output uds_pkg::dp_cmd_t       cmd,
    input  wire uds_pkg::dp_stat_t stat
);
    typedef enum logic [2:0] {ST_IDLE, ST_DECIDE, ST_SEED, ST_OUT} state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_stall       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                if (stat.need_seed)
                    state_next = ST_SEED;
                else
                begin
                    state_next     = ST_OUT;
                    out_valid_next = 1'b1;
                end
            end
            ST_SEED:
            begin
                // One generator step per seed byte, first byte first.
                cmd.lcg_step = 1'b1;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'(uds_pkg::SEED_BYTES - 1))
                begin
                    state_next     = ST_OUT;
                    out_valid_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `UDS_ASSERT_IMPL(a_valid_in_out, clk, rst_n, out_valid_reg == (state_reg == ST_OUT), "out_valid mismatch")
    `UDS_ASSERT_NEXT(a_load_decide, clk, rst_n, cmd.load, state_reg == ST_DECIDE, "load not followed by decide")
    `UDS_ASSERT_IMPL(a_no_load_busy, clk, rst_n, !(cmd.load && out_valid_reg), "load while result pending")
endmodule
`default_nettype wire

/* rtl/core/uds_dpath.sv */
// Datapath: session state, security state, seed generator and response forming.
`default_nettype none
`include "uds_session_security_server_assert.svh"
module uds_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire uds_pkg::in_word_t  in_word,
    input  wire uds_pkg::dp_cmd_t   cmd,
    output uds_pkg::dp_stat_t       stat,
    output uds_pkg::out_word_t      out_word,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    logic [15:0] s3_reg;
    logic [7:0]  step_reg;
    logic [3:0]  maxatt_reg;
    logic [31:0] secret_reg;

    uds_pkg::in_word_t  req_reg;
    uds_pkg::out_word_t resp_reg, resp_next;
    logic        ext_reg, ext_next;
    logic [15:0] timer_reg, timer_next;
    logic        unl_reg, unl_next;
    logic        sv_reg, sv_next;
    logic [31:0] seed_reg;
    logic [3:0]  fail_reg, fail_next;
    logic [31:0] lcg_reg, lcg_next;
    logic        seed_gen;
    logic [16:0] sum;
    logic [31:0] got;
    logic [3:0]  fail_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg     <= 16'd5000;
            step_reg   <= 8'd10;
            maxatt_reg <= 4'd3;
            secret_reg <= 32'd1520778435;
        end
        else if (cfg_we)
        begin
            unique case (uds_pkg::cfg_idx_t'(cfg_index))
                uds_pkg::CFG_S3_TIMEOUT: s3_reg     <= cfg_data[15:0];
                uds_pkg::CFG_TICK_STEP:  step_reg   <= cfg_data[7:0];
                uds_pkg::CFG_MAX_ATT:    maxatt_reg <= cfg_data[3:0];
                uds_pkg::CFG_KEY_SECRET: secret_reg <= cfg_data;
            endcase
        end
    end

    function automatic uds_pkg::out_word_t nrc(input logic [7:0] sid, input logic [7:0] code);
        uds_pkg::out_word_t r;
        r       = '0;
        r.resp_len = 3'd3;
        r.resp0 = uds_pkg::NEG_RESP;
        r.resp1 = sid;
        r.resp2 = code;
        return r;
    endfunction

    function automatic uds_pkg::out_word_t pos(input logic [2:0] n, input logic [7:0] b0,
                                               input logic [7:0] b1);
        uds_pkg::out_word_t r;
        r          = '0;
        r.resp_len = n;
        r.resp0    = b0;
        r.resp1    = b1;
        return r;
    endfunction

    assign sum      = {1'b0, timer_reg} + {9'd0, step_reg};
    assign got      = {req_reg.pay0, req_reg.pay1, req_reg.pay2, req_reg.pay3};
    assign fail_inc = (fail_reg < 4'd15) ? fail_reg + 4'd1 : fail_reg;
    assign lcg_next = lcg_reg * uds_pkg::LCG_MUL + uds_pkg::LCG_ADD;

    always_comb
    begin
        ext_next   = ext_reg;
        timer_next = timer_reg;
        unl_next   = unl_reg;
        sv_next    = sv_reg;
        fail_next  = fail_reg;
        resp_next  = '0;
        seed_gen   = 1'b0;
        if (req_reg.kind)
        begin
            if (ext_reg)
            begin
                if (sum >= {1'b0, s3_reg})
                begin
                    ext_next   = 1'b0;
                    timer_next = '0;
                    unl_next   = 1'b0;
                    sv_next    = 1'b0;
                end
                else
                    timer_next = sum[15:0];
            end
        end
        else if (req_reg.req_len != 8'd0 && req_reg.req_len <= uds_pkg::MAX_REQ_LEN)
        begin
            timer_next = '0;
            unique case (req_reg.service_id)
                uds_pkg::SID_SESSION:
                    if (req_reg.req_len < 8'd2)
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_LEN);
                    else if (req_reg.sub_func == 8'h01)
                    begin
                        ext_next  = 1'b0;
                        unl_next  = 1'b0;
                        sv_next   = 1'b0;
                        resp_next = pos(3'd2, 8'h50, req_reg.sub_func);
                    end
                    else if (req_reg.sub_func == 8'h03)
                    begin
                        ext_next  = 1'b1;
                        resp_next = pos(3'd2, 8'h50, req_reg.sub_func);
                    end
                    else
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_ROOR);
                uds_pkg::SID_RESET:
                    if (req_reg.req_len < 8'd2)
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_LEN);
                    else if (req_reg.sub_func == 8'h01 || req_reg.sub_func == 8'h03)
                    begin
                        resp_next        = pos(3'd2, 8'h51, req_reg.sub_func);
                        resp_next.action = uds_pkg::ACT_RESET;
                    end
                    else
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_SFNS);
                uds_pkg::SID_CLEAR:
                    if (req_reg.req_len < 8'd4)
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_LEN);
                    else
                    begin
                        if (req_reg.clear_ok)
                            resp_next = pos(3'd1, 8'h54, 8'h00);
                        else
                            resp_next = nrc(req_reg.service_id, uds_pkg::NRC_ROOR);
                        resp_next.action = uds_pkg::ACT_CLEAR;
                    end
                uds_pkg::SID_RDID:
                    if (req_reg.req_len < 8'd3)
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_LEN);
                    else
                        resp_next.action = uds_pkg::ACT_FWD;
                uds_pkg::SID_SEC:
                    if (req_reg.req_len < 8'd2)
                        resp_next = nrc(uds_pkg::SID_SEC, uds_pkg::NRC_LEN);
                    else if (!ext_reg)
                        resp_next = nrc(uds_pkg::SID_SEC, uds_pkg::NRC_SNS);
                    else if (req_reg.sub_func == 8'h01)
                    begin
                        if (unl_reg)
                            resp_next = pos(3'd6, 8'h67, 8'h01);
                        else if (fail_reg >= maxatt_reg)
                            resp_next = nrc(uds_pkg::SID_SEC, uds_pkg::NRC_ATT);
                        else
                        begin
                            // Seed bytes are filled in by the generator steps.
                            seed_gen  = 1'b1;
                            sv_next   = 1'b1;
                            resp_next = pos(3'd6, 8'h67, 8'h01);
                        end
                    end
                    else if (req_reg.sub_func == 8'h02)
                    begin
                        if (!sv_reg)
                            resp_next = nrc(uds_pkg::SID_SEC, uds_pkg::NRC_ROOR);
                        else if (req_reg.req_len < 8'd6)
                            resp_next = nrc(uds_pkg::SID_SEC, uds_pkg::NRC_LEN);
                        else
                        begin
                            sv_next = 1'b0;
                            if (got == (seed_reg ^ secret_reg))
                            begin
                                unl_next  = 1'b1;
                                fail_next = '0;
                                resp_next = pos(3'd2, 8'h67, 8'h02);
                            end
                            else
                            begin
                                fail_next = fail_inc;
                                resp_next = nrc(uds_pkg::SID_SEC,
                                    (fail_inc >= maxatt_reg) ? uds_pkg::NRC_ATT
                                                             : uds_pkg::NRC_KEY);
                            end
                        end
                    end
                    else
                        resp_next = nrc(uds_pkg::SID_SEC, uds_pkg::NRC_SFNS);
                uds_pkg::SID_TESTER:
                    if (req_reg.req_len < 8'd2)
                        resp_next = nrc(req_reg.service_id, uds_pkg::NRC_LEN);
                    else if (!req_reg.sub_func[7])
                        resp_next = pos(3'd2, 8'h7E, {1'b0, req_reg.sub_func[6:0]});
                default:
                    resp_next = nrc(req_reg.service_id, uds_pkg::NRC_SNS);
            endcase
        end
    end

    assign stat.need_seed = seed_gen;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg   <= 1'b0;
            timer_reg <= '0;
            unl_reg   <= 1'b0;
            sv_reg    <= 1'b0;
            seed_reg  <= '0;
            fail_reg  <= '0;
            lcg_reg   <= uds_pkg::LCG_INIT;
            resp_reg  <= '0;
        end
        else if (cmd.decide)
        begin
            ext_reg   <= ext_next;
            timer_reg <= timer_next;
            unl_reg   <= unl_next;
            sv_reg    <= sv_next;
            fail_reg  <= fail_next;
            resp_reg  <= resp_next;
        end
        else if (cmd.lcg_step)
        begin
            // Seed bytes shift in from the low end; the response shifts alike.
            lcg_reg        <= lcg_next;
            seed_reg       <= {seed_reg[23:0], lcg_next[23:16]};
            resp_reg.resp2 <= resp_reg.resp3;
            resp_reg.resp3 <= resp_reg.resp4;
            resp_reg.resp4 <= resp_reg.resp5;
            resp_reg.resp5 <= lcg_next[23:16];
        end
    end

    assign out_word = resp_reg;

    `UDS_ASSERT_IMPL(a_timer_default, clk, rst_n, !ext_reg |-> timer_reg == '0, "timer runs in default session")
    `UDS_ASSERT_IMPL(a_unl_ext, clk, rst_n, unl_reg |-> ext_reg, "unlocked outside extended session")
    `UDS_ASSERT_IMPL(a_exclusive, clk, rst_n, !(cmd.decide && cmd.lcg_step), "decide and seed step together")
endmodule
`default_nettype wire

/* rtl/core/uds_session_security_server.sv */
// Top level of the diagnostic session and security access server.
// A word is taken when in_valid is high and in_stall low; the block then works
// on it alone. The accepted word is loaded, decided in the decide state and
// presented in the output state; a seed request first passes through the seed
// state, where the controller steps the LCG multiplier once per seed byte. The
// next word is taken the cycle after the result leaves. Configuration writes
// are accepted in any cycle.
`default_nettype none
module uds_session_security_server (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire uds_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output uds_pkg::out_word_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    uds_pkg::dp_cmd_t  cmd;
    uds_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    uds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    uds_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_data),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule
`default_nettype wire

/* test/uds_session_security_server_tb.sv */
// Self-checking testbench for the UDS session and security access server.
`default_nettype none
module uds_session_security_server_tb;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        uds_pkg::in_word_t w;
        bit                fix_key;
        bit                spoil_key;
    } req_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    uds_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    uds_pkg::out_word_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    req_item_t pending_q[$];
    uds_pkg::out_word_t resp_q[$];
    int unsigned sent_cnt = 0, taken_cnt = 0, gap_left = 0;
    int unsigned cycles = 0, errors = 0, n_resp = 0, n_unlock = 0, n_expire = 0;
    int unsigned hold_cnt = 0;
    bit hold_go = 0, hold_done = 0, no_gaps = 0;

    // Model of the server: configuration and session state.
    logic [15:0] s3_ms, idle_ms;
    logic [7:0]  step_ms;
    logic [3:0]  att_max, fails;
    logic [31:0] secret, seed, lcg;
    logic        ext_mode, unlocked, seed_ok;

    uds_session_security_server u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic uds_pkg::out_word_t neg_resp(logic [7:0] sid, logic [7:0] code);
        uds_pkg::out_word_t r;
        r = '0;
        r.resp_len = 3'd3;
        r.resp0 = uds_pkg::NEG_RESP;
        r.resp1 = sid;
        r.resp2 = code;
        return r;
    endfunction

    function automatic uds_pkg::out_word_t pos_resp(logic [7:0] b0, logic [7:0] b1);
        uds_pkg::out_word_t r;
        r = '0;
        r.resp_len = 3'd2;
        r.resp0 = b0;
        r.resp1 = b1;
        return r;
    endfunction

    function automatic uds_pkg::out_word_t security_access(uds_pkg::in_word_t w);
        uds_pkg::out_word_t r;
        logic [31:0] got;
        r = '0;
        if (w.req_len < 8'd2)
            return neg_resp(uds_pkg::SID_SEC, uds_pkg::NRC_LEN);
        if (!ext_mode)
            return neg_resp(uds_pkg::SID_SEC, uds_pkg::NRC_SNS);
        if (w.sub_func == 8'h01)
        begin
            r = pos_resp(8'h67, 8'h01);
            r.resp_len = 3'd6;
            if (unlocked)
                return r;
            if (fails >= att_max)
                return neg_resp(uds_pkg::SID_SEC, uds_pkg::NRC_ATT);
            for (int k = 0; k < uds_pkg::SEED_BYTES; k++)
            begin
                lcg = lcg * uds_pkg::LCG_MUL + uds_pkg::LCG_ADD;
                seed = {seed[23:0], lcg[23:16]};
            end
            {r.resp2, r.resp3, r.resp4, r.resp5} = seed;
            seed_ok = 1'b1;
            return r;
        end
        if (w.sub_func == 8'h02)
        begin
            if (!seed_ok)
                return neg_resp(uds_pkg::SID_SEC, uds_pkg::NRC_ROOR);
            if (w.req_len < 8'd6)
                return neg_resp(uds_pkg::SID_SEC, uds_pkg::NRC_LEN);
            got = {w.pay0, w.pay1, w.pay2, w.pay3};
            seed_ok = 1'b0;
            if (got == (seed ^ secret))
            begin
                unlocked = 1'b1;
                fails = '0;
                n_unlock++;
                return pos_resp(8'h67, 8'h02);
            end
            if (fails != 4'd15)
                fails = fails + 4'd1;
            return neg_resp(uds_pkg::SID_SEC,
                            (fails >= att_max) ? uds_pkg::NRC_ATT : uds_pkg::NRC_KEY);
        end
        return neg_resp(uds_pkg::SID_SEC, uds_pkg::NRC_SFNS);
    endfunction

    // Works out the response to one word and advances the model state.
    function automatic uds_pkg::out_word_t serve_word(uds_pkg::in_word_t w);
        uds_pkg::out_word_t r;
        logic [16:0] sum;
        r = '0;
        if (w.kind)
        begin
            if (ext_mode)
            begin
                sum = {1'b0, idle_ms} + {9'd0, step_ms};
                if (sum >= {1'b0, s3_ms})
                begin
                    ext_mode = 1'b0;
                    idle_ms = '0;
                    unlocked = 1'b0;
                    seed_ok = 1'b0;
                    n_expire++;
                end
                else
                    idle_ms = sum[15:0];
            end
            return r;
        end
        if (w.req_len == 8'd0 || w.req_len > uds_pkg::MAX_REQ_LEN)
            return r;
        idle_ms = '0;
        unique case (w.service_id)
            uds_pkg::SID_SESSION:
                if (w.req_len < 8'd2)
                    r = neg_resp(w.service_id, uds_pkg::NRC_LEN);
                else if (w.sub_func == 8'h01)
                begin
                    ext_mode = 1'b0;
                    unlocked = 1'b0;
                    seed_ok = 1'b0;
                    r = pos_resp(8'h50, w.sub_func);
                end
                else if (w.sub_func == 8'h03)
                begin
                    ext_mode = 1'b1;
                    r = pos_resp(8'h50, w.sub_func);
                end
                else
                    r = neg_resp(w.service_id, uds_pkg::NRC_ROOR);
            uds_pkg::SID_RESET:
                if (w.req_len < 8'd2)
                    r = neg_resp(w.service_id, uds_pkg::NRC_LEN);
                else if (w.sub_func == 8'h01 || w.sub_func == 8'h03)
                begin
                    r = pos_resp(8'h51, w.sub_func);
                    r.action = uds_pkg::ACT_RESET;
                end
                else
                    r = neg_resp(w.service_id, uds_pkg::NRC_SFNS);
            uds_pkg::SID_CLEAR:
                if (w.req_len < 8'd4)
                    r = neg_resp(w.service_id, uds_pkg::NRC_LEN);
                else
                begin
                    if (w.clear_ok)
                    begin
                        r.resp_len = 3'd1;
                        r.resp0 = 8'h54;
                    end
                    else
                        r = neg_resp(w.service_id, uds_pkg::NRC_ROOR);
                    r.action = uds_pkg::ACT_CLEAR;
                end
            uds_pkg::SID_RDID:
                if (w.req_len < 8'd3)
                    r = neg_resp(w.service_id, uds_pkg::NRC_LEN);
                else
                    r.action = uds_pkg::ACT_FWD;
            uds_pkg::SID_SEC:
                r = security_access(w);
            uds_pkg::SID_TESTER:
                if (w.req_len < 8'd2)
                    r = neg_resp(w.service_id, uds_pkg::NRC_LEN);
                else if (!w.sub_func[7])
                    r = pos_resp(8'h7E, {1'b0, w.sub_func[6:0]});
            default:
                r = neg_resp(w.service_id, uds_pkg::NRC_SNS);
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    // Input side: one word in flight, held until the block takes it.
    always @(negedge clk)
    begin
        req_item_t it;
        if (in_valid && taken_cnt != sent_cnt)
            ;
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_q.size() != 0 && rst_n)
        begin
            it = pending_q.pop_front();
            // Earlier words are all accepted by now, so the model seed is current.
            if (it.fix_key)
            begin
                {it.w.pay0, it.w.pay1, it.w.pay2, it.w.pay3} = seed ^ secret;
                if (it.spoil_key)
                    it.w.pay2[3'($urandom_range(0, 7))] ^= 1'b1;
            end
            in_valid <= 1'b1;
            in_data <= it.w;
            sent_cnt <= sent_cnt + 1;
            if (no_gaps || $urandom_range(0, 99) < 60)
                gap_left <= 0;
            else if ($urandom_range(0, 99) < 85)
                gap_left <= $urandom_range(1, 3);
            else
                gap_left <= $urandom_range(10, 40);
        end
        else
            in_valid <= 1'b0;
    end

    // Output side: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_cnt <= 300;
            hold_done <= 1'b1;
        end
        else if (no_gaps)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 70)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 90)
            out_stall <= 1'b1;
        else
        begin
            out_stall <= 1'b1;
            hold_cnt <= $urandom_range(10, 40);
        end
    end

    always @(posedge clk)
    begin
        uds_pkg::out_word_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                resp_q.push_back(serve_word(in_data));
                taken_cnt++;
            end
            if (out_valid && !out_stall)
            begin
                n_resp++;
                if (resp_q.size() == 0)
                    report("unexpected word", 32'd0, 32'd0);
                else
                begin
                    want = resp_q.pop_front();
                    if (out_data.resp_len !== want.resp_len)
                        report("resp_len", 32'(out_data.resp_len), 32'(want.resp_len));
                    if (out_data.resp0 !== want.resp0)
                        report("resp0", 32'(out_data.resp0), 32'(want.resp0));
                    if (out_data.resp1 !== want.resp1)
                        report("resp1", 32'(out_data.resp1), 32'(want.resp1));
                    if (out_data.resp2 !== want.resp2)
                        report("resp2", 32'(out_data.resp2), 32'(want.resp2));
                    if (out_data.resp3 !== want.resp3)
                        report("resp3", 32'(out_data.resp3), 32'(want.resp3));
                    if (out_data.resp4 !== want.resp4)
                        report("resp4", 32'(out_data.resp4), 32'(want.resp4));
                    if (out_data.resp5 !== want.resp5)
                        report("resp5", 32'(out_data.resp5), 32'(want.resp5));
                    if (out_data.action !== want.action)
                        report("action", 32'(out_data.action), 32'(want.action));
                end
            end
        end
    end

    task automatic write_reg(uds_pkg::cfg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        unique case (idx)
            uds_pkg::CFG_S3_TIMEOUT: s3_ms = val[15:0];
            uds_pkg::CFG_TICK_STEP:  step_ms = val[7:0];
            uds_pkg::CFG_MAX_ATT:    att_max = val[3:0];
            default:                 secret = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_item_t mk(logic [7:0] len, logic [7:0] sid, logic [7:0] sub,
                                     bit tick = 0, bit c_ok = 0);
        req_item_t it;
        it.w = '0;
        it.w.pay0 = 8'($urandom);
        it.w.pay1 = 8'($urandom);
        it.w.pay2 = 8'($urandom);
        it.w.pay3 = 8'($urandom);
        it.w.kind = tick;
        it.w.req_len = len;
        it.w.service_id = sid;
        it.w.sub_func = sub;
        it.w.clear_ok = c_ok;
        it.fix_key = 0;
        it.spoil_key = 0;
        return it;
    endfunction

    function automatic req_item_t key_item(bit spoil);
        req_item_t it;
        it = mk(8'd6, uds_pkg::SID_SEC, 8'h02);
        it.fix_key = 1;
        it.spoil_key = spoil;
        return it;
    endfunction

    // Mostly well-formed requests, with ticks, odd lengths and unknown services mixed in.
    function automatic req_item_t rand_item();
        req_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            it = mk(8'($urandom), 8'($urandom), 8'($urandom), 1);
        else if (pick < 30)
            it = mk(8'd2, uds_pkg::SID_SESSION, ($urandom_range(0, 9) < 8) ?
                    (($urandom_range(0, 3) == 0) ? 8'h01 : 8'h03) : 8'($urandom));
        else if (pick < 34)
            it = mk(8'd2, uds_pkg::SID_RESET,
                    ($urandom_range(0, 1) != 0) ? 8'h01 : 8'($urandom));
        else if (pick < 39)
            it = mk(8'd4, uds_pkg::SID_CLEAR, 8'($urandom), 0, 1'($urandom_range(0, 1)));
        else if (pick < 43)
            it = mk(8'd3, uds_pkg::SID_RDID, 8'($urandom));
        else if (pick < 50)
            it = mk(8'd2, uds_pkg::SID_TESTER, 8'($urandom));
        else if (pick < 66)
            it = mk(8'd2, uds_pkg::SID_SEC,
                    ($urandom_range(0, 9) < 9) ? 8'h01 : 8'($urandom));
        else if (pick < 84)
            it = key_item($urandom_range(0, 2) == 0);
        else if (pick < 90)
            it = mk(8'd6, uds_pkg::SID_SEC, 8'h02);
        else
            it = mk(8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 99) < 8)
            it.w.req_len = 8'($urandom_range(0, 7));
        else if ($urandom_range(0, 99) < 4)
            it.w.req_len = 8'($urandom);
        return it;
    endfunction

    task automatic drain();
        while (!(pending_q.size() == 0 && resp_q.size() == 0 && taken_cnt == sent_cnt))
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        s3_ms = 16'd5000; step_ms = 8'd10; att_max = 4'd3; secret = 32'd1520778435;
        ext_mode = 0; idle_ms = '0; unlocked = 0; seed_ok = 0;
        seed = '0; fails = '0; lcg = uds_pkg::LCG_INIT;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        pending_q.push_back(mk(8'd1, 8'h00, 8'h00, 1));
        pending_q.push_back(mk(8'd0, uds_pkg::SID_SESSION, 8'h03));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SESSION, 8'h02));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SEC, 8'h01));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SESSION, 8'h03));
        pending_q.push_back(mk(8'd6, uds_pkg::SID_SEC, 8'h02));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SEC, 8'h01));
        pending_q.push_back(mk(8'd5, uds_pkg::SID_SEC, 8'h02));
        pending_q.push_back(key_item(0));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SEC, 8'h01));
        pending_q.push_back(mk(8'd1, uds_pkg::SID_SEC, 8'h05));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SEC, 8'h05));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SESSION, 8'h01));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SESSION, 8'h03));
        for (int i = 0; i < 3; i++)
        begin
            pending_q.push_back(mk(8'd2, uds_pkg::SID_SEC, 8'h01));
            pending_q.push_back(key_item(1));
        end
        pending_q.push_back(mk(8'd2, uds_pkg::SID_SEC, 8'h01));
        pending_q.push_back(mk(8'd255, uds_pkg::SID_RESET, 8'h01));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_RESET, 8'h03));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_RESET, 8'h02));
        pending_q.push_back(mk(8'd1, uds_pkg::SID_RESET, 8'h01));
        pending_q.push_back(mk(8'd4, uds_pkg::SID_CLEAR, 8'h00, 0, 1));
        pending_q.push_back(mk(8'd4, uds_pkg::SID_CLEAR, 8'h00, 0, 0));
        pending_q.push_back(mk(8'd3, uds_pkg::SID_CLEAR, 8'h00, 0, 1));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_RDID, 8'hF1));
        pending_q.push_back(mk(8'd3, uds_pkg::SID_RDID, 8'hF1));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_TESTER, 8'h00));
        pending_q.push_back(mk(8'd2, uds_pkg::SID_TESTER, 8'hFF));
        pending_q.push_back(mk(8'd1, uds_pkg::SID_TESTER, 8'h00));
        pending_q.push_back(mk(8'd1, uds_pkg::SID_SESSION, 8'h01));
        pending_q.push_back(mk(8'd2, 8'hFF, 8'hFF));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(uds_pkg::CFG_S3_TIMEOUT, 32'd1);
                    write_reg(uds_pkg::CFG_TICK_STEP, 32'd1);
                    write_reg(uds_pkg::CFG_MAX_ATT, 32'd1);
                    write_reg(uds_pkg::CFG_KEY_SECRET, 32'd0);
                end
                1:
                begin
                    write_reg(uds_pkg::CFG_S3_TIMEOUT, 32'd65535);
                    write_reg(uds_pkg::CFG_TICK_STEP, 32'd255);
                    write_reg(uds_pkg::CFG_MAX_ATT, 32'd15);
                    write_reg(uds_pkg::CFG_KEY_SECRET, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(uds_pkg::CFG_S3_TIMEOUT, 32'd60);
                    write_reg(uds_pkg::CFG_TICK_STEP, 32'd7);
                    write_reg(uds_pkg::CFG_MAX_ATT, 32'd2);
                    write_reg(uds_pkg::CFG_KEY_SECRET, $urandom);
                end
                3:
                begin
                    // A limit of zero refuses every seed.
                    write_reg(uds_pkg::CFG_MAX_ATT, 32'd0);
                    write_reg(uds_pkg::CFG_S3_TIMEOUT, 32'd300);
                    write_reg(uds_pkg::CFG_TICK_STEP, 32'd20);
                end
                default:
                begin
                    write_reg(uds_pkg::CFG_S3_TIMEOUT, $urandom_range(1, 400));
                    write_reg(uds_pkg::CFG_TICK_STEP, $urandom_range(1, 255));
                    write_reg(uds_pkg::CFG_MAX_ATT, $urandom_range(1, 15));
                    write_reg(uds_pkg::CFG_KEY_SECRET, $urandom);
                end
            endcase
            no_gaps = (ph == 4);
            for (int i = 0; i < 195; i++)
                pending_q.push_back(rand_item());
            if (ph == 2)
            begin
                repeat (40) @(posedge clk);
                hold_go = 1'b1;
            end
            drain();
        end
        repeat (20) @(posedge clk);

        $display("Checked %0d responses over seven register settings, directed and random.",
                 n_resp);
        $display("Keys accepted: %0d, extended sessions timed out: %0d.", n_unlock, n_expire);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
